### hdl/dses_pkg.sv
// Shared types and constants of the depth-sorted entry stack.
package dses_pkg;

	localparam int DEPTH_W          = 32;
	localparam int PAYLOAD_W        = 32;
	localparam int COUNT_OUT_W      = 7;
	localparam int CAPACITY_DEF     = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_SORT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_SORT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     phase;
	} cell_cmd_t;

endpackage

### hdl/dses_cell.sv
// One stack cell: holds one entry and shifts or swaps it with its neighbors.
module dses_cell import dses_pkg::*; #(
	parameter int INDEX        = 0,
	parameter int CNT_W        = 7,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                      clk,
	input  cell_cmd_t                 cmd,
	input  logic [CNT_W-1:0]          count,
	input  logic signed [DEPTH_W-1:0] up_depth,
	input  logic [PAYLOAD_BITS-1:0]   up_payload,
	input  logic signed [DEPTH_W-1:0] dn_depth,
	input  logic [PAYLOAD_BITS-1:0]   dn_payload,
	input  logic                      swap_up,
	output logic signed [DEPTH_W-1:0] depth,
	output logic [PAYLOAD_BITS-1:0]   payload,
	output logic                      swap_dn
);

	localparam logic [CNT_W-1:0] NEXT_IDX   = CNT_W'(INDEX + 1);
	localparam logic             PAIR_PHASE = 1'(INDEX % 2);

	logic signed [DEPTH_W-1:0] depth_q;
	logic [PAYLOAD_BITS-1:0]   payload_q;

	// This cell is the upper one of its pair; the entry below moves up only when
	// strictly deeper, which keeps equal depths in their prior order.
	assign swap_dn = (cmd.op == CELL_SORT) && (cmd.phase == PAIR_PHASE) &&
	                 (NEXT_IDX < count) && (dn_depth > depth_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_PUSH: begin
				depth_q   <= up_depth;
				payload_q <= up_payload;
			end
			CELL_POP: begin
				depth_q   <= dn_depth;
				payload_q <= dn_payload;
			end
			CELL_SORT: begin
				if (swap_dn) begin
					depth_q   <= dn_depth;
					payload_q <= dn_payload;
				end else if (swap_up) begin
					depth_q   <= up_depth;
					payload_q <= up_payload;
				end
			end
			default: begin
			end
		endcase
	end

	assign depth   = depth_q;
	assign payload = payload_q;

endmodule

### hdl/dses_ctrl.sv
// Request/response handshake, entry count and sort pass sequencing.
module dses_ctrl import dses_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  action_t          action,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic             refused,
	output logic [CNT_W-1:0] count,
	output cell_cmd_t        cmd
);

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pass_q;
	logic             busy_q;
	logic             rsp_valid_q;
	logic             refused_q;
	logic             accept;
	logic             full;
	logic             empty;

	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign req_ready = !busy_q && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.phase = pass_q[0];
		if (busy_q) begin
			cmd.op = CELL_SORT;
		end else if (accept) begin
			case (action)
				ACT_PUSH: cmd.op = full  ? CELL_HOLD : CELL_PUSH;
				ACT_POP:  cmd.op = empty ? CELL_HOLD : CELL_POP;
				default:  cmd.op = CELL_HOLD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pass_q      <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			refused_q   <= 1'b0;
		end else begin
			if (accept) begin
				refused_q <= ((action == ACT_PUSH) && full) || ((action == ACT_POP) && empty);
				case (action)
					ACT_PUSH: begin
						if (!full) count_q <= count_q + ONE_C;
					end
					ACT_POP: begin
						if (!empty) count_q <= count_q - ONE_C;
					end
					ACT_CLEAR: count_q <= '0;
					default: begin
					end
				endcase
				// A sort of two or more entries runs one pass per entry before answering.
				if (action == ACT_SORT && count_q > ONE_C) begin
					busy_q      <= 1'b1;
					pass_q      <= '0;
					rsp_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= 1'b1;
				end
			end else if (busy_q) begin
				pass_q <= pass_q + ONE_C;
				if (pass_q == count_q - ONE_C) begin
					busy_q      <= 1'b0;
					rsp_valid_q <= 1'b1;
				end
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign refused   = refused_q;
	assign count     = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C) else $error("entry count above capacity");

	a_no_rsp_in_sort: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !rsp_valid_q) else $error("response shown during sort");

	a_sort_answers: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> rsp_valid_q) else $error("sort ended without response");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_PUSH && !full) |=> count_q == $past(count_q) + ONE_C)
		else $error("push did not grow the count");

	a_sort_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> count_q == $past(count_q)) else $error("count changed during sort");

endmodule

### hdl/depth_sorted_event_stack_core.sv
// Top level of the depth-sorted entry stack: control plus a chain of entry cells.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  request  | req_valid / req_ready | action, depth_key, payload
//  response | rsp_valid / rsp_ready | is_empty, entry_count, top_depth, top_payload,
//           |                       | refused
//
// Push, pop and clear answer in the cycle after the request is taken.
// A sort of n >= 2 entries runs n odd-even transposition passes over the cell chain,
// so the pass counter ends the sort and raises the response after the last pass.
// A new request is taken once the previous response leaves, in that same cycle.
// Reset empties the stack; cell contents are left as they are and never read.
module depth_sorted_event_stack_core import dses_pkg::*; #(
	parameter int CAPACITY     = CAPACITY_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [1:0]                action,
	input  logic signed [DEPTH_W-1:0] depth_key,
	input  logic [PAYLOAD_W-1:0]      payload,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic                      is_empty,
	output logic [COUNT_OUT_W-1:0]    entry_count,
	output logic signed [DEPTH_W-1:0] top_depth,
	output logic [PAYLOAD_W-1:0]      top_payload,
	output logic                      refused
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]          count;
	cell_cmd_t                 cmd;
	logic [PAYLOAD_BITS-1:0]   new_payload;
	logic signed [DEPTH_W-1:0] cell_depth   [CAPACITY];
	logic [PAYLOAD_BITS-1:0]   cell_payload [CAPACITY];
	logic                      cell_swap    [CAPACITY];
	logic [PAYLOAD_W-1:0]      head_payload;

	dses_ctrl #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action_t'(action)),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.refused   (refused),
		.count     (count),
		.cmd       (cmd)
	);

	generate
		if (PAYLOAD_BITS > PAYLOAD_W) begin : g_pl_wide
			assign new_payload  = {{(PAYLOAD_BITS - PAYLOAD_W){1'b0}}, payload};
			assign head_payload = cell_payload[0][PAYLOAD_W-1:0];
		end else if (PAYLOAD_BITS == PAYLOAD_W) begin : g_pl_same
			assign new_payload  = payload;
			assign head_payload = cell_payload[0];
		end else begin : g_pl_narrow
			assign new_payload  = payload[PAYLOAD_BITS-1:0];
			assign head_payload = {{(PAYLOAD_W - PAYLOAD_BITS){1'b0}}, cell_payload[0]};
		end

		if (CNT_W >= COUNT_OUT_W) begin : g_cnt_trunc
			assign entry_count = count[COUNT_OUT_W-1:0];
		end else begin : g_cnt_ext
			assign entry_count = {{(COUNT_OUT_W - CNT_W){1'b0}}, count};
		end

		// Cell 0 is the top of the stack; push shifts the chain down, pop shifts it up.
		for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
			logic signed [DEPTH_W-1:0] up_d;
			logic [PAYLOAD_BITS-1:0]   up_p;
			logic signed [DEPTH_W-1:0] dn_d;
			logic [PAYLOAD_BITS-1:0]   dn_p;
			logic                      sw_up;

			if (k == 0) begin : g_head
				assign up_d  = depth_key;
				assign up_p  = new_payload;
				assign sw_up = 1'b0;
			end else begin : g_body
				assign up_d  = cell_depth[k-1];
				assign up_p  = cell_payload[k-1];
				assign sw_up = cell_swap[k-1];
			end

			if (k == CAPACITY - 1) begin : g_tail
				assign dn_d = cell_depth[k];
				assign dn_p = cell_payload[k];
			end else begin : g_link
				assign dn_d = cell_depth[k+1];
				assign dn_p = cell_payload[k+1];
			end

			dses_cell #(
				.INDEX        (k),
				.CNT_W        (CNT_W),
				.PAYLOAD_BITS (PAYLOAD_BITS)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.count      (count),
				.up_depth   (up_d),
				.up_payload (up_p),
				.dn_depth   (dn_d),
				.dn_payload (dn_p),
				.swap_up    (sw_up),
				.depth      (cell_depth[k]),
				.payload    (cell_payload[k]),
				.swap_dn    (cell_swap[k])
			);
		end
	endgenerate

	assign is_empty    = (count == '0);
	assign top_depth   = is_empty ? '0 : cell_depth[0];
	assign top_payload = is_empty ? '0 : head_payload;

endmodule
